### src/port_allow_rule_table_defines.svh
// assertion macros shared by the rule table rtl
`ifndef PORT_ALLOW_RULE_TABLE_DEFINES_SVH
`define PORT_ALLOW_RULE_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PART_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("port_allow_rule_table check failed");

// next-cycle implication, disabled while reset is low
`define PART_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("port_allow_rule_table check failed");

`endif

### src/part_pkg.sv
package part_pkg;

    localparam int RULE_COUNT_DEF = 24;

    localparam int PORT_W  = 16;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [PORT_W-1:0] DEFAULT_PORT_A_RST = 16'd80;
    localparam logic [PORT_W-1:0] DEFAULT_PORT_B_RST = 16'd443;

    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_PORT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    localparam logic CFG_DEFAULT_PORT_A = 1'b0;
    localparam logic CFG_DEFAULT_PORT_B = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } t_state;

endpackage

### src/port_allow_rule_table.sv
// channel   direction  signals                               width
// input     in         i_valid/o_ready, i_command/i_port/    2/16/1
//                      i_allow_in
// result    out        o_valid/i_ready, o_status/o_allow_out 2/1
// config    in         i_cfg_we, i_cfg_index, i_cfg_data     1/1/16
//
// set and query with a nonzero port scan the rule memory one entry a cycle,
// through the registered read of the rule memory and its one comparator.
// clear, unused codes and port zero skip the scan and go straight to resolve.
// reset (synchronous, active low) empties the table and loads the default ports 80 and 443.
// the result register holds one item; a stalled result lets the next item scan
// and holds it in resolve until the result is taken.
`include "port_allow_rule_table_defines.svh"

module port_allow_rule_table #(
    parameter int RULE_COUNT = part_pkg::RULE_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [part_pkg::CMD_W-1:0] i_command,
    input  logic [part_pkg::PORT_W-1:0] i_port,
    input  logic                       i_allow_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [part_pkg::STAT_W-1:0] o_status,
    output logic                       o_allow_out,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [part_pkg::PORT_W-1:0] i_cfg_data
);

    localparam int IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_COUNT - 1);

    // rule memory: port and allow bit per entry, used flags in flops
    logic [part_pkg::PORT_W-1:0] mem_port  [RULE_COUNT];
    logic                        mem_allow [RULE_COUNT];

    part_pkg::t_state r_state, n_state;
    logic [RULE_COUNT-1:0]        r_used, n_used;
    logic [part_pkg::PORT_W-1:0]  r_def_a, r_def_b;
    logic                         r_out_valid, n_out_valid;

    logic [part_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [part_pkg::PORT_W-1:0]  r_port, n_port;
    logic                         r_allow, n_allow;
    logic [IDX_W-1:0]             r_addr, n_addr;
    logic                         r_addr_vld, n_addr_vld;
    logic [IDX_W-1:0]             r_cmp_idx, n_cmp_idx;
    logic                         r_cmp_vld, n_cmp_vld;
    logic                         r_hit, n_hit;
    logic [IDX_W-1:0]             r_hit_idx, n_hit_idx;
    logic                         r_hit_allow, n_hit_allow;
    logic                         r_free_vld, n_free_vld;
    logic [IDX_W-1:0]             r_free_idx, n_free_idx;
    logic [part_pkg::STAT_W-1:0]  r_status, n_status;
    logic                         r_allow_out, n_allow_out;

    logic [part_pkg::PORT_W-1:0]  r_rd_port;
    logic                         r_rd_allow;

    logic                         w_we;
    logic [IDX_W-1:0]             w_waddr;
    logic                         w_wport_en;

    logic w_accept;
    logic w_slot_free;

    assign o_ready     = (r_state == part_pkg::S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_allow_out = r_allow_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_allow[w_waddr] <= r_allow;
            if (w_wport_en) begin
                mem_port[w_waddr] <= r_port;
            end
        end
        r_rd_port  <= mem_port[r_addr];
        r_rd_allow <= mem_allow[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= part_pkg::S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_def_a     <= part_pkg::DEFAULT_PORT_A_RST;
            r_def_b     <= part_pkg::DEFAULT_PORT_B_RST;
            r_addr_vld  <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_addr_vld  <= n_addr_vld;
            r_cmp_vld   <= n_cmp_vld;
            r_hit       <= n_hit;
            r_free_vld  <= n_free_vld;
            if (i_cfg_we) begin
                if (i_cfg_index == part_pkg::CFG_DEFAULT_PORT_A) begin
                    r_def_a <= i_cfg_data;
                end else begin
                    r_def_b <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_port      <= n_port;
        r_allow     <= n_allow;
        r_addr      <= n_addr;
        r_cmp_idx   <= n_cmp_idx;
        r_hit_idx   <= n_hit_idx;
        r_hit_allow <= n_hit_allow;
        r_free_idx  <= n_free_idx;
        r_status    <= n_status;
        r_allow_out <= n_allow_out;
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_port      = r_port;
        n_allow     = r_allow;
        n_addr      = r_addr;
        n_addr_vld  = r_addr_vld;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_allow = r_hit_allow;
        n_free_vld  = r_free_vld;
        n_free_idx  = r_free_idx;
        n_status    = r_status;
        n_allow_out = r_allow_out;
        w_we        = 1'b0;
        w_waddr     = r_hit_idx;
        w_wport_en  = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            part_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd      = i_command;
                    n_port     = i_port;
                    n_allow    = i_allow_in;
                    n_addr     = '0;
                    n_addr_vld = 1'b1;
                    n_cmp_vld  = 1'b0;
                    n_hit      = 1'b0;
                    n_free_vld = 1'b0;
                    if ((i_command == part_pkg::CMD_SET || i_command == part_pkg::CMD_QUERY)
                            && i_port != '0) begin
                        n_state = part_pkg::S_SCAN;
                    end else begin
                        n_state = part_pkg::S_RESOLVE;
                    end
                end
            end
            part_pkg::S_SCAN: begin
                // address stage feeds the registered read, which feeds the compare stage
                n_cmp_idx = r_addr;
                n_cmp_vld = r_addr_vld;
                if (r_addr_vld) begin
                    if (r_addr == LAST_IDX) begin
                        n_addr_vld = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    if (r_used[r_cmp_idx]) begin
                        if (!r_hit && r_rd_port == r_port) begin
                            n_hit       = 1'b1;
                            n_hit_idx   = r_cmp_idx;
                            n_hit_allow = r_rd_allow;
                        end
                    end else if (!r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                    if (r_cmp_idx == LAST_IDX) begin
                        n_state = part_pkg::S_RESOLVE;
                    end
                end
            end
            part_pkg::S_RESOLVE: begin
                if (w_slot_free) begin
                    n_state     = part_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = part_pkg::ST_OK;
                    n_allow_out = 1'b0;
                    case (r_cmd)
                        part_pkg::CMD_CLEAR: begin
                            n_used = '0;
                        end
                        part_pkg::CMD_SET: begin
                            if (r_port == '0) begin
                                n_status = part_pkg::ST_BAD_PORT;
                            end else if (r_hit) begin
                                w_we    = 1'b1;
                                w_waddr = r_hit_idx;
                            end else if (r_free_vld) begin
                                w_we               = 1'b1;
                                w_waddr            = r_free_idx;
                                w_wport_en         = 1'b1;
                                n_used[r_free_idx] = 1'b1;
                            end else begin
                                n_status = part_pkg::ST_FULL;
                            end
                        end
                        part_pkg::CMD_QUERY: begin
                            if (r_port == '0) begin
                                n_status = part_pkg::ST_BAD_PORT;
                            end else if (r_hit) begin
                                n_allow_out = r_hit_allow;
                            end else begin
                                n_allow_out = (r_port == r_def_a) || (r_port == r_def_b);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = part_pkg::S_IDLE;
            end
        endcase
    end

    `PART_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept,
        r_state != part_pkg::S_IDLE)
    `PART_ASSERT_NOW(a_cmp_in_range, i_clk, i_rst_n, r_cmp_vld,
        r_cmp_idx <= LAST_IDX)
    `PART_ASSERT_NOW(a_full_means_all_used, i_clk, i_rst_n,
        r_out_valid && r_status == part_pkg::ST_FULL, &r_used)
    `PART_ASSERT_NOW(a_hit_entry_used, i_clk, i_rst_n,
        r_state == part_pkg::S_RESOLVE && r_cmd == part_pkg::CMD_SET && r_hit,
        r_used[r_hit_idx])
    `PART_ASSERT_NOW(a_allow_only_ok, i_clk, i_rst_n, r_out_valid && r_allow_out,
        r_status == part_pkg::ST_OK)

endmodule
